[rtl/core/rrss_pkg.sv]
// Shared types, constants and helpers of the round-robin slice scheduler.
package rrss_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned IdW        = 8;
  localparam int unsigned BurstW     = 16;
  localparam int unsigned EntryW     = IdW + BurstW;

  localparam logic [BurstW-1:0] QuantumReset = BurstW'(4);

  typedef enum logic {
    ReqEnqueue  = 1'b0,
    ReqDispatch = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    StatEnqueued   = 2'd0,
    StatDispatched = 2'd1,
    StatEmpty      = 2'd2,
    StatFull       = 2'd3
  } status_e;

  typedef enum logic {
    SchedIdle = 1'b0,
    SchedRead = 1'b1
  } sched_state_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [IdW-1:0]     task_id;
    logic [BurstW-1:0]  burst_time;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [IdW-1:0]     granted_id;
    logic [BurstW-1:0]  remaining_after;
    logic               requeued;
  } rsp_t;

  typedef struct packed {
    logic [IdW-1:0]     task_id;
    logic [BurstW-1:0]  burst;
  } entry_t;

  // Circular pointer advance, wraps at QueueDepth-1.
  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] res;
    if (ptr == PtrW'(QueueDepth - 1)) begin
      res = '0;
    end else begin
      res = ptr + PtrW'(1);
    end
    return res;
  endfunction

endpackage

[rtl/core/rrss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rrss_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/round_robin_slice_scheduler_unit.sv]
// Top level of the round-robin time-slice scheduler.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_req_i) carries one request:
//   enqueue a task {id, burst} or dispatch one time slice. Output channel
//   (out_valid_o / out_stall_i / out_rsp_o) returns exactly one response per
//   request, in request order. cfg_we_i / cfg_wdata_i write the time quantum
//   (0 acts as 1); write only while the block is idle.
// Request handling:
//   Enqueue, full reject and empty dispatch: response registered at the
//   accept edge. A dispatch of a queued task reads the task memory
//   (registered read port), then in state SchedRead updates the entry and
//   writes it back. The single read-modify-write path of the task memory
//   allows only one request in flight at a time.
// Reset:
//   Queue empty, pointers zero, quantum 4, no response pending. Task memory
//   contents are not cleared; the entry count guards every read.
// Stall:
//   The response is held in an output register. While out_stall_i holds a
//   pending response, a new request is not accepted.
module round_robin_slice_scheduler_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rrss_pkg::req_t       in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rrss_pkg::rsp_t       out_rsp_o,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i
);

  // Control and queue state
  rrss_pkg::sched_state_e            state_q, state_d;
  logic [rrss_pkg::PtrW-1:0]         head_q, head_d;
  logic [rrss_pkg::PtrW-1:0]         tail_q, tail_d;
  logic [rrss_pkg::CntW-1:0]         count_q, count_d;
  logic [rrss_pkg::BurstW-1:0]       quantum_q;
  logic                              out_valid_q, out_valid_d;
  rrss_pkg::rsp_t                    out_rsp_q, out_rsp_d;

  // Memory port signals
  logic                              mem_we;
  logic [rrss_pkg::PtrW-1:0]         mem_waddr;
  rrss_pkg::entry_t                  mem_wdata;
  logic                              mem_re;
  logic [rrss_pkg::EntryW-1:0]       mem_rdata;
  rrss_pkg::entry_t                  head_entry;

  logic                              slot_free;
  logic                              accept;
  logic                              is_full;
  logic                              is_empty;
  logic [rrss_pkg::BurstW-1:0]       quantum_eff;
  logic                              requeue;
  logic [rrss_pkg::BurstW-1:0]       left_after;

  rrss_ram #(
    .Width (rrss_pkg::EntryW),
    .Depth (rrss_pkg::QueueDepth)
  ) u_task_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (head_q),
    .rdata_o (mem_rdata)
  );

  assign head_entry = rrss_pkg::entry_t'(mem_rdata);

  // Output register is free if empty or drained this cycle.
  assign slot_free  = !(out_valid_q && out_stall_i);
  assign in_stall_o = (state_q != rrss_pkg::SchedIdle) || !slot_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_full  = (count_q == rrss_pkg::CntW'(rrss_pkg::QueueDepth));
  assign is_empty = (count_q == '0);

  // Slice arithmetic on the task just read from the head.
  assign quantum_eff = (quantum_q == '0) ? rrss_pkg::BurstW'(1) : quantum_q;
  assign requeue     = head_entry.burst > quantum_eff;
  assign left_after  = head_entry.burst - quantum_eff;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;
    mem_we      = 1'b0;
    mem_waddr   = tail_q;
    mem_wdata   = '{task_id: in_req_i.task_id, burst: in_req_i.burst_time};
    mem_re      = 1'b0;

    unique case (state_q)
      rrss_pkg::SchedIdle: begin
        if (accept) begin
          unique case (in_req_i.req_type)
            rrss_pkg::ReqEnqueue: begin
              out_valid_d = 1'b1;
              out_rsp_d   = '0;
              if (is_full) begin
                out_rsp_d.status = rrss_pkg::StatFull;
              end else begin
                out_rsp_d.status = rrss_pkg::StatEnqueued;
                mem_we  = 1'b1;
                tail_d  = rrss_pkg::next_ptr(tail_q);
                count_d = count_q + rrss_pkg::CntW'(1);
              end
            end
            rrss_pkg::ReqDispatch: begin
              if (is_empty) begin
                out_valid_d      = 1'b1;
                out_rsp_d        = '0;
                out_rsp_d.status = rrss_pkg::StatEmpty;
              end else begin
                // Fetch the head task; finish next cycle.
                mem_re  = 1'b1;
                state_d = rrss_pkg::SchedRead;
              end
            end
            default: ;
          endcase
        end
      end
      rrss_pkg::SchedRead: begin
        // Output slot is empty here: it was free at accept and nothing loaded since.
        out_valid_d               = 1'b1;
        out_rsp_d.status          = rrss_pkg::StatDispatched;
        out_rsp_d.granted_id      = head_entry.task_id;
        out_rsp_d.remaining_after = requeue ? left_after : '0;
        out_rsp_d.requeued        = requeue;
        head_d                    = rrss_pkg::next_ptr(head_q);
        if (requeue) begin
          mem_we    = 1'b1;
          mem_wdata = '{task_id: head_entry.task_id, burst: left_after};
          tail_d    = rrss_pkg::next_ptr(tail_q);
        end else begin
          count_d = count_q - rrss_pkg::CntW'(1);
        end
        state_d = rrss_pkg::SchedIdle;
      end
      default: state_d = rrss_pkg::SchedIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrss_pkg::SchedIdle;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      quantum_q   <= rrss_pkg::QuantumReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        quantum_q <= cfg_wdata_i;
      end
    end
  end

  // Response payload, no reset needed.
  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
